[rtl/core/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg - shared types and sizes for the ray/sphere intersection unit
// Word widths of the wide arithmetic units and the records that travel
// alongside them down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

   // Multiplier: unsigned operands split into two halves
   localparam int MulW   = 68;
   localparam int MulH   = MulW / 2;
   localparam int ProdW  = 2 * MulW;
   localparam int MulLat = 2;

   // Square root: radicand width (even), one result bit per stage
   localparam int SqW     = 134;
   localparam int RootW   = SqW / 2;
   localparam int SqrtLat = SqW / 2;

   // Restoring divider: one quotient bit per stage
   localparam int NumW   = 84;
   localparam int DenW   = 66;
   localparam int DivLat = NumW;

   typedef enum logic [2:0] {
      RegCenterX  = 3'd0,
      RegCenterY  = 3'd1,
      RegCenterZ  = 3'd2,
      RegRadius   = 3'd3,
      RegMaterial = 3'd4
   } reg_index_type;

   // Ray relative to the sphere centre
   typedef struct packed {
      logic             vld;
      logic [2:0][32:0] v;
      logic [2:0][31:0] d;
      logic [31:0]      tmin;
      logic [31:0]      best;
   } ray_type;

   typedef struct packed {
      ray_type          ray;
      logic [2:0][63:0] dd;
      logic [2:0][64:0] dv;
      logic [2:0][65:0] vv;
      logic [61:0]      rr;
   } prod_type;

   // Quadratic coefficients as sign and magnitude
   typedef struct packed {
      ray_type     ray;
      logic        hneg;
      logic [66:0] hmag;
      logic [63:0] a;
      logic        kneg;
      logic [66:0] kmag;
      logic        azero;
   } quad_type;

   typedef struct packed {
      ray_type     ray;
      logic        hneg;
      logic [66:0] hmag;
      logic [63:0] a;
      logic        miss;
   } root_type;

   typedef struct packed {
      ray_type ray;
      logic    xneg;
      logic    yneg;
      logic    miss;
   } tdiv_type;

   typedef struct packed {
      ray_type     ray;
      logic        miss;
      logic [85:0] t1;
      logic [85:0] t2;
   } pick_type;

   typedef struct packed {
      logic             vld;
      logic             hit;
      logic             upd;
      logic [31:0]      ts;
      logic [2:0][32:0] v;
      logic [2:0][31:0] d;
   } hitc_type;

   typedef struct packed {
      hitc_type         hc;
      logic [2:0][63:0] dts;
   } nprod_type;

   typedef struct packed {
      logic             vld;
      logic             hit;
      logic             upd;
      logic [31:0]      ts;
      logic [2:0]       nneg;
      logic [2:0][64:0] nmag;
   } norm_type;

   typedef struct packed {
      logic        vld;
      logic        hit;
      logic        upd;
      logic [31:0] ts;
      logic [2:0]  nneg;
      logic        lzero;
   } ndiv_type;

endpackage

`default_nettype wire

[rtl/core/rsi_mul.sv]
// ----------------------------------------------------------------------------
// rsi_mul - two-stage unsigned multiplier
// Four half-width partial products, registered, then summed.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_mul (
   input  logic                       clock,
   input  logic                       en,
   input  logic [rsi_pkg::MulW-1:0]   a,
   input  logic [rsi_pkg::MulW-1:0]   b,
   output logic [rsi_pkg::ProdW-1:0]  p
);

   logic [rsi_pkg::MulW-1:0]  pp_ff [4];
   logic [rsi_pkg::MulW-1:0]  pp_in [4];
   logic [rsi_pkg::ProdW-1:0] p_ff;
   logic [rsi_pkg::ProdW-1:0] p_in;

   always_comb begin
      pp_in[0] = a[rsi_pkg::MulH-1:0] * b[rsi_pkg::MulH-1:0];
      pp_in[1] = a[rsi_pkg::MulH-1:0] * b[rsi_pkg::MulW-1:rsi_pkg::MulH];
      pp_in[2] = a[rsi_pkg::MulW-1:rsi_pkg::MulH] * b[rsi_pkg::MulH-1:0];
      pp_in[3] = a[rsi_pkg::MulW-1:rsi_pkg::MulH] * b[rsi_pkg::MulW-1:rsi_pkg::MulH];
   end

   always_comb begin
      p_in = rsi_pkg::ProdW'(pp_ff[0])
           + ((rsi_pkg::ProdW'(pp_ff[1]) + rsi_pkg::ProdW'(pp_ff[2])) << rsi_pkg::MulH)
           + (rsi_pkg::ProdW'(pp_ff[3]) << rsi_pkg::MulW);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) pp_ff[i] <= pp_in[i];
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

[rtl/core/rsi_sqrt.sv]
// ----------------------------------------------------------------------------
// rsi_sqrt - pipelined integer square root
// Floor of the root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt (
   input  logic                      clock,
   input  logic                      en,
   input  logic [rsi_pkg::SqW-1:0]   arg,
   output logic [rsi_pkg::RootW-1:0] root
);

   logic [rsi_pkg::SqW-1:0] x_ff [rsi_pkg::SqrtLat];
   logic [rsi_pkg::SqW-1:0] x_in [rsi_pkg::SqrtLat];
   logic [rsi_pkg::SqW-1:0] r_ff [rsi_pkg::SqrtLat];
   logic [rsi_pkg::SqW-1:0] r_in [rsi_pkg::SqrtLat];

   always_comb begin
      logic [rsi_pkg::SqW-1:0] sx;
      logic [rsi_pkg::SqW-1:0] sr;
      logic [rsi_pkg::SqW-1:0] bitv;
      logic [rsi_pkg::SqW:0]   trial;
      for (int j = 0; j < rsi_pkg::SqrtLat; j++) begin
         if (j == 0) begin
            sx = arg;
            sr = '0;
         end else begin
            sx = x_ff[j-1];
            sr = r_ff[j-1];
         end
         bitv  = {{(rsi_pkg::SqW-1){1'b0}}, 1'b1} << (rsi_pkg::SqW - 2 - 2 * j);
         trial = {1'b0, sr} + {1'b0, bitv};
         if ({1'b0, sx} >= trial) begin
            x_in[j] = sx - trial[rsi_pkg::SqW-1:0];
            r_in[j] = (sr >> 1) + bitv;
         end else begin
            x_in[j] = sx;
            r_in[j] = sr >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < rsi_pkg::SqrtLat; j++) begin
            x_ff[j] <= x_in[j];
            r_ff[j] <= r_in[j];
         end
      end
   end

   assign root = r_ff[rsi_pkg::SqrtLat-1][rsi_pkg::RootW-1:0];

endmodule

`default_nettype wire

[rtl/core/rsi_div.sv]
// ----------------------------------------------------------------------------
// rsi_div - pipelined restoring divider
// Unsigned quotient and remainder, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div (
   input  logic                     clock,
   input  logic                     en,
   input  logic [rsi_pkg::NumW-1:0] num,
   input  logic [rsi_pkg::DenW-1:0] den,
   output logic [rsi_pkg::NumW-1:0] quo,
   output logic [rsi_pkg::DenW-1:0] rem
);

   logic [rsi_pkg::DenW-1:0] rem_ff [rsi_pkg::DivLat];
   logic [rsi_pkg::DenW-1:0] rem_in [rsi_pkg::DivLat];
   logic [rsi_pkg::NumW-1:0] nq_ff  [rsi_pkg::DivLat];
   logic [rsi_pkg::NumW-1:0] nq_in  [rsi_pkg::DivLat];
   logic [rsi_pkg::DenW-1:0] den_ff [rsi_pkg::DivLat];
   logic [rsi_pkg::DenW-1:0] den_in [rsi_pkg::DivLat];

   always_comb begin
      logic [rsi_pkg::DenW-1:0] sr;
      logic [rsi_pkg::NumW-1:0] snq;
      logic [rsi_pkg::DenW-1:0] dn;
      logic [rsi_pkg::DenW:0]   sh;
      logic [rsi_pkg::DenW:0]   diff;
      logic                     ge;
      for (int j = 0; j < rsi_pkg::DivLat; j++) begin
         if (j == 0) begin
            sr  = '0;
            snq = num;
            dn  = den;
         end else begin
            sr  = rem_ff[j-1];
            snq = nq_ff[j-1];
            dn  = den_ff[j-1];
         end
         sh   = {sr, snq[rsi_pkg::NumW-1]};
         diff = sh - {1'b0, dn};
         ge   = (sh >= {1'b0, dn});
         rem_in[j] = ge ? diff[rsi_pkg::DenW-1:0] : sh[rsi_pkg::DenW-1:0];
         nq_in[j]  = {snq[rsi_pkg::NumW-2:0], ge};
         den_in[j] = dn;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < rsi_pkg::DivLat; j++) begin
            rem_ff[j] <= rem_in[j];
            nq_ff[j]  <= nq_in[j];
            den_ff[j] <= den_in[j];
         end
      end
   end

   assign quo = nq_ff[rsi_pkg::DivLat-1];
   assign rem = rem_ff[rsi_pkg::DivLat-1];

endmodule

`default_nettype wire

[rtl/core/ray_sphere_intersect_unit.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit - ray against one configured sphere, Q16.16
// Solves the ray/sphere quadratic exactly, picks the nearer root at or past
// the minimum distance, and gives distance, unit normal and material when
// the hit beats the current best.
// ----------------------------------------------------------------------------
//
//  channel | ports   | transfer                      | contents
//  --------+---------+-------------------------------+---------------------------
//  ray in  | req_*   | req_tvalid & req_tready       | origin, dir, min, best
//  result  | rsp_*   | rsp_tvalid & rsp_tready       | hit/update flags, dist,
//          |         |                               | normal, material
//  csr     | csr_*   | psel & penable & pwrite       | centre, radius, material
//
//  One ray per clock, sustained while the output is not stalled. A ray passes
//  from input transfer to rsp_tvalid through the two 67-stage square roots and
//  the two banks of 84-stage restoring dividers (root solve, then normal length and normalise).
//  Synchronous reset clears the valid bits of every stage; data registers
//  are not reset. A stalled output freezes the whole pipeline in place:
//  req_tready follows that one advance enable, so nothing drops or repeats.
//  Bubbles are not squeezed out: while the output waits, no ray enters.
//
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_unit (
   input  logic         clock,
   input  logic         reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, min_distance,
   // best_distance (32 bits each, from bit 0 up)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,
   // hit_distance[31:0], normal_x[49:32], normal_y[67:50], normal_z[85:68],
   // hit_material[93:86], zero pad[95:94]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,
   // hit[0], update[1]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic signed [85:0] TMax = 86'sh7FFF_FFFF;
   localparam logic signed [85:0] TMin = -86'sh8000_0000;

   // ---------------- configuration registers ----------------
   logic [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0] rad_ff;
   logic [7:0]  mat_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= 31'd65536;
         mat_ff <= '0;
      end else if (csr_wr) begin
         case (rsi_pkg::reg_index_type'(csr_paddr[4:2]))
            rsi_pkg::RegCenterX:  cx_ff  <= csr_pwdata;
            rsi_pkg::RegCenterY:  cy_ff  <= csr_pwdata;
            rsi_pkg::RegCenterZ:  cz_ff  <= csr_pwdata;
            rsi_pkg::RegRadius:   rad_ff <= csr_pwdata[30:0];
            rsi_pkg::RegMaterial: mat_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (rsi_pkg::reg_index_type'(csr_paddr[4:2]))
         rsi_pkg::RegCenterX:  csr_prdata = cx_ff;
         rsi_pkg::RegCenterY:  csr_prdata = cy_ff;
         rsi_pkg::RegCenterZ:  csr_prdata = cz_ff;
         rsi_pkg::RegRadius:   csr_prdata = {1'b0, rad_ff};
         rsi_pkg::RegMaterial: csr_prdata = {24'b0, mat_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // one advance enable for the whole pipe
   logic adv;
   logic out_vld_ff;

   assign adv        = ~out_vld_ff | rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0: V = O - C ----------------
   rsi_pkg::ray_type s0_ff, s0_in;

   always_comb begin
      logic [2:0][31:0] cen;
      cen = {cz_ff, cy_ff, cx_ff};
      s0_in.vld = req_tvalid;
      for (int k = 0; k < 3; k++) begin
         s0_in.v[k] = 33'($signed(req_tdata[32*k +: 32])) - 33'($signed(cen[k]));
         s0_in.d[k] = req_tdata[96 + 32*k +: 32];
      end
      s0_in.tmin = req_tdata[223:192];
      s0_in.best = req_tdata[255:224];
   end

   // ---------------- stage 1: component products ----------------
   rsi_pkg::prod_type s1_ff, s1_in;

   always_comb begin
      logic signed [65:0] de, ve, pdd, pdv, pvv;
      logic        [61:0] re;
      s1_in.ray = s0_ff;
      for (int k = 0; k < 3; k++) begin
         de  = 66'($signed(s0_ff.d[k]));
         ve  = 66'($signed(s0_ff.v[k]));
         pdd = de * de;
         pdv = de * ve;
         pvv = ve * ve;
         s1_in.dd[k] = pdd[63:0];
         s1_in.dv[k] = pdv[64:0];
         s1_in.vv[k] = pvv[65:0];
      end
      re       = 62'(rad_ff);
      s1_in.rr = re * re;
   end

   // ---------------- stage 2: A, H, K ----------------
   rsi_pkg::quad_type s2_ff, s2_in;

   always_comb begin
      logic signed [66:0] hs;
      logic signed [67:0] ks;
      logic        [63:0] as;
      hs = '0;
      ks = -68'(s1_ff.rr);
      as = '0;
      for (int k = 0; k < 3; k++) begin
         hs = hs + 67'($signed(s1_ff.dv[k]));
         ks = ks + 68'(s1_ff.vv[k]);
         as = as + s1_ff.dd[k];
      end
      s2_in.ray   = s1_ff.ray;
      s2_in.hneg  = hs[66];
      s2_in.hmag  = hs[66] ? 67'(-hs) : 67'(hs);
      s2_in.a     = as;
      s2_in.kneg  = ks[67];
      s2_in.kmag  = ks[67] ? 67'(-ks) : 67'(ks);
      s2_in.azero = (as == '0);
   end

   // ---------------- H*H and A*|K| ----------------
   logic [rsi_pkg::ProdW-1:0] p_hh, p_ak;
   rsi_pkg::quad_type q1_ff [rsi_pkg::MulLat];

   rsi_mul u_mul_hh (
      .clock (clock),
      .en    (adv),
      .a     ({1'b0, s2_ff.hmag}),
      .b     ({1'b0, s2_ff.hmag}),
      .p     (p_hh)
   );

   rsi_mul u_mul_ak (
      .clock (clock),
      .en    (adv),
      .a     ({4'b0, s2_ff.a}),
      .b     ({1'b0, s2_ff.kmag}),
      .p     (p_ak)
   );

   // ---------------- stage 5: discriminant ----------------
   rsi_pkg::root_type       s5_ff, s5_in;
   logic [rsi_pkg::SqW-1:0] s5_q_ff, s5_q_in;

   always_comb begin
      rsi_pkg::quad_type ql;
      logic [136:0]      qs;
      ql = q1_ff[rsi_pkg::MulLat-1];
      if (ql.kneg) qs = {1'b0, p_hh} + {1'b0, p_ak};
      else         qs = {1'b0, p_hh} - {1'b0, p_ak};
      s5_in.ray  = ql.ray;
      s5_in.hneg = ql.hneg;
      s5_in.hmag = ql.hmag;
      s5_in.a    = ql.a;
      s5_in.miss = ql.azero | (~ql.kneg & qs[136]);
      s5_q_in    = qs[rsi_pkg::SqW-1:0];
   end

   // ---------------- root of the discriminant ----------------
   logic [rsi_pkg::RootW-1:0] s_root;
   rsi_pkg::root_type         r2_ff [rsi_pkg::SqrtLat];

   rsi_sqrt u_sqrt_q (
      .clock (clock),
      .en    (adv),
      .arg   (s5_q_ff),
      .root  (s_root)
   );

   // ---------------- stage 6: root numerators ----------------
   rsi_pkg::tdiv_type        s6_ff, s6_in;
   logic [rsi_pkg::NumW-1:0] s6_xnum_ff, s6_xnum_in, s6_ynum_ff, s6_ynum_in;
   logic [rsi_pkg::DenW-1:0] s6_den_ff, s6_den_in;

   always_comb begin
      rsi_pkg::root_type  rl;
      logic signed [68:0] nh, sv, xs, ys;
      logic        [67:0] xm, ym;
      rl = r2_ff[rsi_pkg::SqrtLat-1];
      nh = rl.hneg ? 69'(rl.hmag) : -69'(rl.hmag);
      sv = $signed({2'b0, s_root});
      xs = nh - sv;
      ys = nh + sv;
      xm = xs[68] ? 68'(-xs) : 68'(xs);
      ym = ys[68] ? 68'(-ys) : 68'(ys);
      s6_in.ray  = rl.ray;
      s6_in.xneg = xs[68];
      s6_in.yneg = ys[68];
      s6_in.miss = rl.miss;
      s6_xnum_in = {xm, 16'b0};
      s6_ynum_in = {ym, 16'b0};
      s6_den_in  = {2'b0, rl.a};
   end

   // ---------------- t1, t2 division ----------------
   logic [rsi_pkg::NumW-1:0] q_x, q_y;
   logic [rsi_pkg::DenW-1:0] rm_x, rm_y;
   rsi_pkg::tdiv_type        d3_ff [rsi_pkg::DivLat];

   rsi_div u_div_t1 (
      .clock (clock),
      .en    (adv),
      .num   (s6_xnum_ff),
      .den   (s6_den_ff),
      .quo   (q_x),
      .rem   (rm_x)
   );

   rsi_div u_div_t2 (
      .clock (clock),
      .en    (adv),
      .num   (s6_ynum_ff),
      .den   (s6_den_ff),
      .quo   (q_y),
      .rem   (rm_y)
   );

   // ---------------- stage 7: floor to signed roots ----------------
   rsi_pkg::pick_type s7_ff, s7_in;

   always_comb begin
      rsi_pkg::tdiv_type dl;
      logic [85:0]       tx, ty;
      dl = d3_ff[rsi_pkg::DivLat-1];
      tx = {2'b0, q_x};
      ty = {2'b0, q_y};
      s7_in.ray  = dl.ray;
      s7_in.miss = dl.miss;
      s7_in.t1   = dl.xneg ? -(tx + 86'(rm_x != '0)) : tx;
      s7_in.t2   = dl.yneg ? -(ty + 86'(rm_y != '0)) : ty;
   end

   // ---------------- stage 8: pick, saturate, compare ----------------
   rsi_pkg::hitc_type s8_ff, s8_in;

   always_comb begin
      logic signed [85:0] tm, pk;
      logic               c1, c2, hit;
      logic        [31:0] ts;
      tm  = 86'($signed(s7_ff.ray.tmin));
      c1  = $signed(s7_ff.t1) >= tm;
      c2  = $signed(s7_ff.t2) >= tm;
      pk  = c1 ? $signed(s7_ff.t1) : $signed(s7_ff.t2);
      hit = ~s7_ff.miss & (c1 | c2);
      if (pk > TMax)      ts = 32'h7FFF_FFFF;
      else if (pk < TMin) ts = 32'h8000_0000;
      else                ts = pk[31:0];
      s8_in.vld = s7_ff.ray.vld;
      s8_in.hit = hit;
      s8_in.upd = hit & ($signed(ts) < $signed(s7_ff.ray.best));
      s8_in.ts  = ts;
      s8_in.v   = s7_ff.ray.v;
      s8_in.d   = s7_ff.ray.d;
   end

   // ---------------- stage 9: D * t ----------------
   rsi_pkg::nprod_type s9_ff, s9_in;

   always_comb begin
      logic signed [63:0] de, te;
      s9_in.hc = s8_ff;
      te = 64'($signed(s8_ff.ts));
      for (int k = 0; k < 3; k++) begin
         de = 64'($signed(s8_ff.d[k]));
         s9_in.dts[k] = de * te;
      end
   end

   // ---------------- stage 10: unnormalised normal ----------------
   rsi_pkg::norm_type s10_ff, s10_in;

   always_comb begin
      logic signed [65:0] nk;
      s10_in.vld = s9_ff.hc.vld;
      s10_in.hit = s9_ff.hc.hit;
      s10_in.upd = s9_ff.hc.upd;
      s10_in.ts  = s9_ff.hc.ts;
      for (int k = 0; k < 3; k++) begin
         nk = (66'($signed(s9_ff.hc.v[k])) <<< 16) + 66'($signed(s9_ff.dts[k]));
         s10_in.nneg[k] = nk[65];
         s10_in.nmag[k] = nk[65] ? 65'(-nk) : 65'(nk);
      end
   end

   // ---------------- N_k squared ----------------
   logic [2:0][rsi_pkg::ProdW-1:0] p_nn;
   rsi_pkg::norm_type              n4_ff [rsi_pkg::MulLat];

   for (genvar k = 0; k < 3; k++) begin : g_nmul
      rsi_mul u_mul_nn (
         .clock (clock),
         .en    (adv),
         .a     ({3'b0, s10_ff.nmag[k]}),
         .b     ({3'b0, s10_ff.nmag[k]}),
         .p     (p_nn[k])
      );
   end

   // ---------------- stage 11: N.N ----------------
   rsi_pkg::norm_type       s11_ff, s11_in;
   logic [rsi_pkg::SqW-1:0] s11_nn_ff, s11_nn_in;

   always_comb begin
      s11_in    = n4_ff[rsi_pkg::MulLat-1];
      s11_nn_in = p_nn[0][rsi_pkg::SqW-1:0] + p_nn[1][rsi_pkg::SqW-1:0]
                + p_nn[2][rsi_pkg::SqW-1:0];
   end

   // ---------------- normal length ----------------
   logic [rsi_pkg::RootW-1:0] l_root;
   rsi_pkg::norm_type         n5_ff [rsi_pkg::SqrtLat];

   rsi_sqrt u_sqrt_n (
      .clock (clock),
      .en    (adv),
      .arg   (s11_nn_ff),
      .root  (l_root)
   );

   // ---------------- stage 12: normalise set-up ----------------
   rsi_pkg::ndiv_type             s12_ff, s12_in;
   logic [2:0][rsi_pkg::NumW-1:0] s12_num_ff, s12_num_in;
   logic [rsi_pkg::DenW-1:0]      s12_den_ff, s12_den_in;

   always_comb begin
      rsi_pkg::norm_type nl;
      nl = n5_ff[rsi_pkg::SqrtLat-1];
      s12_in.vld   = nl.vld;
      s12_in.hit   = nl.hit;
      s12_in.upd   = nl.upd;
      s12_in.ts    = nl.ts;
      s12_in.nneg  = nl.nneg;
      s12_in.lzero = (l_root == '0);
      for (int k = 0; k < 3; k++) s12_num_in[k] = {3'b0, nl.nmag[k], 16'b0};
      s12_den_in = l_root[rsi_pkg::DenW-1:0];
   end

   // ---------------- N_k / L ----------------
   logic [2:0][rsi_pkg::NumW-1:0] q_n;
   logic [2:0][rsi_pkg::DenW-1:0] rm_n;
   rsi_pkg::ndiv_type             n6_ff [rsi_pkg::DivLat];

   for (genvar k = 0; k < 3; k++) begin : g_ndiv
      rsi_div u_div_n (
         .clock (clock),
         .en    (adv),
         .num   (s12_num_ff[k]),
         .den   (s12_den_ff),
         .quo   (q_n[k]),
         .rem   (rm_n[k])
      );
   end

   // ---------------- output register ----------------
   logic              out_vld_in;
   logic [1:0]        out_user_ff, out_user_in;
   logic [31:0]       out_dist_ff, out_dist_in;
   logic [2:0][17:0]  out_nrm_ff, out_nrm_in;
   logic [7:0]        out_mat_ff, out_mat_in;

   always_comb begin
      rsi_pkg::ndiv_type ol;
      ol = n6_ff[rsi_pkg::DivLat-1];
      out_vld_in  = ol.vld;
      out_user_in = {ol.upd, ol.hit};
      out_dist_in = ol.upd ? ol.ts : '0;
      out_mat_in  = ol.upd ? mat_ff : '0;
      for (int k = 0; k < 3; k++) begin
         if (!ol.upd || ol.lzero) out_nrm_in[k] = '0;
         else if (ol.nneg[k])     out_nrm_in[k] = -q_n[k][17:0];
         else                     out_nrm_in[k] = q_n[k][17:0];
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld     <= 1'b0;
         s1_ff.ray.vld <= 1'b0;
         s2_ff.ray.vld <= 1'b0;
         for (int i = 0; i < rsi_pkg::MulLat; i++) q1_ff[i].ray.vld <= 1'b0;
         s5_ff.ray.vld <= 1'b0;
         for (int i = 0; i < rsi_pkg::SqrtLat; i++) r2_ff[i].ray.vld <= 1'b0;
         s6_ff.ray.vld <= 1'b0;
         for (int i = 0; i < rsi_pkg::DivLat; i++) d3_ff[i].ray.vld <= 1'b0;
         s7_ff.ray.vld <= 1'b0;
         s8_ff.vld     <= 1'b0;
         s9_ff.hc.vld  <= 1'b0;
         s10_ff.vld    <= 1'b0;
         for (int i = 0; i < rsi_pkg::MulLat; i++) n4_ff[i].vld <= 1'b0;
         s11_ff.vld    <= 1'b0;
         for (int i = 0; i < rsi_pkg::SqrtLat; i++) n5_ff[i].vld <= 1'b0;
         s12_ff.vld    <= 1'b0;
         for (int i = 0; i < rsi_pkg::DivLat; i++) n6_ff[i].vld <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else if (adv) begin
         s0_ff      <= s0_in;
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         q1_ff[0]   <= s2_ff;
         for (int i = 1; i < rsi_pkg::MulLat; i++) q1_ff[i] <= q1_ff[i-1];
         s5_ff      <= s5_in;
         s5_q_ff    <= s5_q_in;
         r2_ff[0]   <= s5_ff;
         for (int i = 1; i < rsi_pkg::SqrtLat; i++) r2_ff[i] <= r2_ff[i-1];
         s6_ff      <= s6_in;
         s6_xnum_ff <= s6_xnum_in;
         s6_ynum_ff <= s6_ynum_in;
         s6_den_ff  <= s6_den_in;
         d3_ff[0]   <= s6_ff;
         for (int i = 1; i < rsi_pkg::DivLat; i++) d3_ff[i] <= d3_ff[i-1];
         s7_ff      <= s7_in;
         s8_ff      <= s8_in;
         s9_ff      <= s9_in;
         s10_ff     <= s10_in;
         n4_ff[0]   <= s10_ff;
         for (int i = 1; i < rsi_pkg::MulLat; i++) n4_ff[i] <= n4_ff[i-1];
         s11_ff     <= s11_in;
         s11_nn_ff  <= s11_nn_in;
         n5_ff[0]   <= s11_ff;
         for (int i = 1; i < rsi_pkg::SqrtLat; i++) n5_ff[i] <= n5_ff[i-1];
         s12_ff     <= s12_in;
         s12_num_ff <= s12_num_in;
         s12_den_ff <= s12_den_in;
         n6_ff[0]   <= s12_ff;
         for (int i = 1; i < rsi_pkg::DivLat; i++) n6_ff[i] <= n6_ff[i-1];
         out_vld_ff  <= out_vld_in;
         out_user_ff <= out_user_in;
         out_dist_ff <= out_dist_in;
         out_nrm_ff  <= out_nrm_in;
         out_mat_ff  <= out_mat_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tdata  = {2'b0, out_mat_ff, out_nrm_ff[2], out_nrm_ff[1], out_nrm_ff[0],
                        out_dist_ff};

endmodule

`default_nettype wire
